### hw/rtl/rau_pkg.sv
// Shared types, constants, helper functions and the microcode ROM of the rational arithmetic unit.
package rau_pkg;

  // Operand and result widths
  localparam int OW      = 16;
  localparam int RES_W   = 33;
  localparam int PROD_W  = 2 * OW;
  localparam int K_W     = $clog2(OW);
  localparam int CNT_W   = $clog2(OW + 1);
  localparam int PC_W    = 4;
  localparam int ACT_W   = 3;
  localparam int IN_DATA_W  = ((4 * OW + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * RES_W + 7) / 8) * 8;

  // Operation selector codes; 5 to 7 pass A through
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_SUB    = 3'd1,
    ACT_MUL    = 3'd2,
    ACT_DIV    = 3'd3,
    ACT_REDUCE = 3'd4
  } action_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    UOP_NOP        = 4'd0,
    UOP_LOAD       = 4'd1,
    UOP_MUL_P      = 4'd2,
    UOP_MUL_Q      = 4'd3,
    UOP_MUL_D      = 4'd4,
    UOP_COMBINE    = 4'd5,
    UOP_GCD_STEP   = 4'd6,
    UOP_DIV_INIT   = 4'd7,
    UOP_DIV_STEP   = 4'd8,
    UOP_REDUCE_FIN = 4'd9,
    UOP_EMIT       = 4'd10
  } uop_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER       = 3'd0,
    COND_NO_INPUT    = 3'd1,
    COND_REDUCE      = 3'd2,
    COND_GCD_BUSY    = 3'd3,
    COND_DIV_BUSY    = 3'd4,
    COND_OUT_BLOCKED = 3'd5,
    COND_ALWAYS      = 3'd6
  } cond_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_FETCH      = 4'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH   = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL_P      = 4'd2;
  localparam logic [PC_W-1:0] PC_MUL_Q      = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL_D      = 4'd4;
  localparam logic [PC_W-1:0] PC_COMBINE    = 4'd5;
  localparam logic [PC_W-1:0] PC_GCD        = 4'd6;
  localparam logic [PC_W-1:0] PC_DIV_INIT   = 4'd7;
  localparam logic [PC_W-1:0] PC_DIV        = 4'd8;
  localparam logic [PC_W-1:0] PC_REDUCE_FIN = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT       = 4'd10;

  // One control word: operation, jump condition and target, and whether
  // the fall-through path returns to fetch
  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
    logic            last;
  } ucode_t;

  // Control from sequencer to datapath
  typedef struct packed {
    uop_t uop;
  } ctrl_t;

  // Status flags from datapath to sequencer
  typedef struct packed {
    logic is_reduce;
    logic gcd_busy;
    logic div_busy;
    logic out_blocked;
  } status_t;

  // Microcode ROM
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{uop: UOP_NOP, cond: COND_ALWAYS, tgt: PC_FETCH, last: 1'b1};
    unique case (pc)
      PC_FETCH:      w = '{uop: UOP_LOAD,       cond: COND_NO_INPUT,    tgt: PC_FETCH,  last: 1'b0};
      PC_DISPATCH:   w = '{uop: UOP_NOP,        cond: COND_REDUCE,      tgt: PC_GCD,    last: 1'b0};
      PC_MUL_P:      w = '{uop: UOP_MUL_P,      cond: COND_NEVER,       tgt: PC_FETCH,  last: 1'b0};
      PC_MUL_Q:      w = '{uop: UOP_MUL_Q,      cond: COND_NEVER,       tgt: PC_FETCH,  last: 1'b0};
      PC_MUL_D:      w = '{uop: UOP_MUL_D,      cond: COND_NEVER,       tgt: PC_FETCH,  last: 1'b0};
      PC_COMBINE:    w = '{uop: UOP_COMBINE,    cond: COND_ALWAYS,      tgt: PC_EMIT,   last: 1'b0};
      PC_GCD:        w = '{uop: UOP_GCD_STEP,   cond: COND_GCD_BUSY,    tgt: PC_GCD,    last: 1'b0};
      PC_DIV_INIT:   w = '{uop: UOP_DIV_INIT,   cond: COND_NEVER,       tgt: PC_FETCH,  last: 1'b0};
      PC_DIV:        w = '{uop: UOP_DIV_STEP,   cond: COND_DIV_BUSY,    tgt: PC_DIV,    last: 1'b0};
      PC_REDUCE_FIN: w = '{uop: UOP_REDUCE_FIN, cond: COND_NEVER,       tgt: PC_FETCH,  last: 1'b0};
      PC_EMIT:       w = '{uop: UOP_EMIT,       cond: COND_OUT_BLOCKED, tgt: PC_EMIT,   last: 1'b1};
      default:       w = '{uop: UOP_NOP,        cond: COND_ALWAYS,      tgt: PC_FETCH,  last: 1'b1};
    endcase
    return w;
  endfunction

  // Magnitude of a two's complement operand as an unsigned value
  function automatic logic [OW-1:0] mag(input logic [OW-1:0] a);
    return a[OW-1] ? (~a + 1'b1) : a;
  endfunction

endpackage

### hw/rtl/rau_sequencer.sv
// Microcode sequencer: program counter, ROM lookup and conditional jumps.
module rau_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  rau_pkg::status_t  status,
  output rau_pkg::ctrl_t    ctrl
);

  logic [rau_pkg::PC_W-1:0] pc_r;
  logic [rau_pkg::PC_W-1:0] pc_nxt;
  rau_pkg::ucode_t          cw;
  logic                     jump;

  assign cw       = rau_pkg::ucode(pc_r);
  assign ctrl.uop = cw.uop;

  // Jump condition select
  always_comb begin
    unique case (cw.cond)
      rau_pkg::COND_NEVER:       jump = 1'b0;
      rau_pkg::COND_NO_INPUT:    jump = ~in_tvalid;
      rau_pkg::COND_REDUCE:      jump = status.is_reduce;
      rau_pkg::COND_GCD_BUSY:    jump = status.gcd_busy;
      rau_pkg::COND_DIV_BUSY:    jump = status.div_busy;
      rau_pkg::COND_OUT_BLOCKED: jump = status.out_blocked;
      rau_pkg::COND_ALWAYS:      jump = 1'b1;
      default:                   jump = 1'b1;
    endcase
  end

  // Next address: target, fetch, or next step
  always_comb begin
    priority if (jump) begin
      pc_nxt = cw.tgt;
    end else if (cw.last) begin
      pc_nxt = rau_pkg::PC_FETCH;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rau_pkg::PC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### hw/rtl/rau_datapath.sv
// Datapath: operand registers, shared multiplier, binary gcd, dual divider and output register.
module rau_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rau_pkg::ctrl_t                    ctrl,
  output rau_pkg::status_t                  status,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rau_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [rau_pkg::ACT_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rau_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser
);

  localparam int OW    = rau_pkg::OW;
  localparam int RES_W = rau_pkg::RES_W;

  // Operand registers
  rau_pkg::action_t          op_r;
  logic signed [OW-1:0]      an_r, ad_r, bn_r, bd_r;
  logic                      zd_r;

  // Product and result registers
  logic signed [RES_W-1:0]   p_r, q_r, d_r;
  logic [RES_W-1:0]          res_num_r, res_den_r;

  // gcd and divider registers
  logic [OW-1:0]             u_r, v_r, u_nxt, v_nxt;
  logic [rau_pkg::K_W-1:0]   k_r, k_nxt;
  logic [OW-1:0]             g_r;
  logic [OW-1:0]             qn_r, qd_r;
  logic [OW-1:0]             rn_r, rd_r;
  logic [rau_pkg::CNT_W-1:0] cnt_r;

  // Output register
  logic                      out_valid_r;
  logic [RES_W-1:0]          out_num_r, out_den_r;
  logic                      out_zd_r;

  logic                      accept;
  logic                      emit;
  logic signed [OW-1:0]      mul_x, mul_y;
  logic signed [rau_pkg::PROD_W-1:0] prod;
  logic signed [RES_W-1:0]   prod_ext;
  logic [OW:0]               rn_sh, rd_sh;
  logic                      rn_ge, rd_ge;
  logic [RES_W-1:0]          mn_ext, md_ext;
  rau_pkg::action_t          act_in;

  assign act_in = rau_pkg::action_t'(in_tuser);

  // Handshake and status
  assign in_tready          = (ctrl.uop == rau_pkg::UOP_LOAD);
  assign accept             = in_tready & in_tvalid;
  assign status.is_reduce   = (op_r == rau_pkg::ACT_REDUCE);
  assign status.gcd_busy    = (u_r != '0) && (v_r != '0);
  assign status.div_busy    = (cnt_r != '0);
  assign status.out_blocked = out_valid_r & ~out_tready;
  assign emit               = (ctrl.uop == rau_pkg::UOP_EMIT) & ~status.out_blocked;

  // Shared multiplier operand select
  always_comb begin
    unique case (ctrl.uop)
      rau_pkg::UOP_MUL_P: begin
        mul_x = an_r;
        mul_y = (op_r == rau_pkg::ACT_MUL) ? bn_r : bd_r;
      end
      rau_pkg::UOP_MUL_Q: begin
        mul_x = bn_r;
        mul_y = ad_r;
      end
      default: begin
        mul_x = ad_r;
        mul_y = (op_r == rau_pkg::ACT_DIV) ? bn_r : bd_r;
      end
    endcase
  end

  assign prod     = mul_x * mul_y;
  assign prod_ext = RES_W'(prod);

  // One binary gcd step
  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    k_nxt = k_r;
    priority if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + 1'b1;
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r >= v_r) begin
      u_nxt = (u_r - v_r) >> 1;
    end else begin
      v_nxt = (v_r - u_r) >> 1;
    end
  end

  // Restoring divide step for both parts against the same divisor
  assign rn_sh = {rn_r, qn_r[OW-1]};
  assign rd_sh = {rd_r, qd_r[OW-1]};
  assign rn_ge = (rn_sh >= {1'b0, g_r});
  assign rd_ge = (rd_sh >= {1'b0, g_r});

  assign mn_ext = RES_W'(qn_r);
  assign md_ext = RES_W'(qd_r);

  // Control-state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.uop == rau_pkg::UOP_DIV_INIT) begin
        cnt_r <= rau_pkg::CNT_W'(OW);
      end else if ((ctrl.uop == rau_pkg::UOP_DIV_STEP) && status.div_busy) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (ctrl.uop)
      rau_pkg::UOP_LOAD: begin
        if (accept) begin
          op_r <= act_in;
          an_r <= in_tdata[OW-1:0];
          ad_r <= in_tdata[2*OW-1:OW];
          bn_r <= in_tdata[3*OW-1:2*OW];
          bd_r <= in_tdata[4*OW-1:3*OW];
          u_r  <= rau_pkg::mag(in_tdata[OW-1:0]);
          v_r  <= rau_pkg::mag(in_tdata[2*OW-1:OW]);
          k_r  <= '0;
          // Exact denominator is zero when one of its factors is zero
          unique case (act_in)
            rau_pkg::ACT_ADD, rau_pkg::ACT_SUB, rau_pkg::ACT_MUL:
              zd_r <= (in_tdata[2*OW-1:OW] == '0) || (in_tdata[4*OW-1:3*OW] == '0);
            rau_pkg::ACT_DIV:
              zd_r <= (in_tdata[2*OW-1:OW] == '0) || (in_tdata[3*OW-1:2*OW] == '0);
            default:
              zd_r <= (in_tdata[2*OW-1:OW] == '0);
          endcase
        end
      end
      rau_pkg::UOP_MUL_P: p_r <= prod_ext;
      rau_pkg::UOP_MUL_Q: q_r <= prod_ext;
      rau_pkg::UOP_MUL_D: d_r <= prod_ext;
      rau_pkg::UOP_COMBINE: begin
        unique case (op_r)
          rau_pkg::ACT_ADD: begin
            res_num_r <= p_r + q_r;
            res_den_r <= d_r;
          end
          rau_pkg::ACT_SUB: begin
            res_num_r <= p_r - q_r;
            res_den_r <= d_r;
          end
          rau_pkg::ACT_MUL, rau_pkg::ACT_DIV: begin
            res_num_r <= p_r;
            res_den_r <= d_r;
          end
          default: begin
            res_num_r <= RES_W'(an_r);
            res_den_r <= RES_W'(ad_r);
          end
        endcase
      end
      rau_pkg::UOP_GCD_STEP: begin
        if (status.gcd_busy) begin
          u_r <= u_nxt;
          v_r <= v_nxt;
          k_r <= k_nxt;
        end
      end
      rau_pkg::UOP_DIV_INIT: begin
        // gcd is the surviving nonzero value times the common power of two
        g_r  <= (u_r | v_r) << k_r;
        qn_r <= rau_pkg::mag(an_r);
        qd_r <= rau_pkg::mag(ad_r);
        rn_r <= '0;
        rd_r <= '0;
      end
      rau_pkg::UOP_DIV_STEP: begin
        if (status.div_busy) begin
          rn_r <= rn_ge ? OW'(rn_sh - {1'b0, g_r}) : OW'(rn_sh);
          rd_r <= rd_ge ? OW'(rd_sh - {1'b0, g_r}) : OW'(rd_sh);
          qn_r <= {qn_r[OW-2:0], rn_ge};
          qd_r <= {qd_r[OW-2:0], rd_ge};
        end
      end
      rau_pkg::UOP_REDUCE_FIN: begin
        // 0/0 has no gcd and stays as it is
        if (g_r == '0) begin
          res_num_r <= '0;
          res_den_r <= '0;
        end else begin
          res_num_r <= an_r[OW-1] ? (~mn_ext + 1'b1) : mn_ext;
          res_den_r <= ad_r[OW-1] ? (~md_ext + 1'b1) : md_ext;
        end
      end
      rau_pkg::UOP_EMIT: begin
        if (emit) begin
          out_num_r <= res_num_r;
          out_den_r <= res_den_r;
          out_zd_r  <= zd_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rau_pkg::OUT_DATA_W - 2 * RES_W){1'b0}}, out_den_r, out_num_r};
  assign out_tuser  = out_zd_r;

endmodule

### hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: microcode sequencer plus datapath.
//
// Usage: one transaction on the in_ channel carries an operation in in_tuser
// (0 add, 1 subtract, 2 multiply, 3 divide, 4 reduce A, others pass A) and
// the fractions A and B in in_tdata. One transaction on the out_ channel
// returns the resulting fraction in out_tdata and a zero-denominator flag
// in out_tuser. Arithmetic results are not reduced.
// Arithmetic items make three passes through the single 16x16 multiplier,
// then combine the products and emit. Reduce items run the binary gcd, one
// step per cycle, at most about 32 steps, then the 16-step shared divider,
// then the final sign fix, and emit. One item is in work at a time; in_tready
// is high only while the sequencer waits at its fetch step, which follows
// the emit step, so a new item is taken only after the last one is emitted.
// Reset (rst_n low, synchronous) returns the sequencer to fetch and clears
// out_tvalid. When the receiver stalls, the result holds in the output
// register, the next item is still accepted and computed, and the sequencer
// waits at its emit step until the output register frees.
module rational_arithmetic_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rau_pkg::IN_DATA_W-1:0]     in_tdata,  // a_num, a_den, b_num, b_den
  input  logic [rau_pkg::ACT_W-1:0]         in_tuser,  // action
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rau_pkg::OUT_DATA_W-1:0]    out_tdata, // res_num, res_den, zero pad
  output logic                              out_tuser  // zero_den
);

  rau_pkg::ctrl_t   ctrl;
  rau_pkg::status_t status;

  rau_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .status    (status),
    .ctrl      (ctrl)
  );

  rau_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .status     (status),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
